// ===== design/tbo_pkg.sv =====
// Package with widths, types and register codes of the triangle-box overlap test.
`timescale 1ns / 1ps
package tbo_pkg;

  // Coordinate width and the widths of the exact intermediate values.
  localparam int CW  = 32;             // coordinate, signed Q16.16
  localparam int PW  = CW + 3;         // doubled vertex relative to box center
  localparam int EW  = CW + 4;         // edge vector component
  localparam int PPW = 2 * EW;         // one product of edge components
  localparam int RPW = EW + CW;        // edge magnitude times box size
  localparam int NW  = 2 * EW + 1;     // normal component and edge projection
  localparam int SPL = (NW + 1) / 2;   // split point of the normal for the plane products
  localparam int NHW = NW - SPL;       // width of the upper normal part
  localparam int CLW = SPL + 1 + PW;   // lower plane product (signed)
  localparam int CHW = NHW + PW;       // upper plane product (signed)
  localparam int RLW = SPL + CW;       // lower radius product (unsigned)
  localparam int RHW = NHW + CW;       // upper radius product (unsigned)
  localparam int DW  = NW + PW + 4;    // plane distance sums
  localparam int CFG_IW = 3;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [PW-1:0]  p_t;
  typedef logic signed [EW-1:0]  e_t;
  typedef logic        [CW-1:0]  h_t;
  typedef logic        [EW-1:0]  emag_t;
  typedef logic signed [PPW-1:0] pp_t;
  typedef logic        [RPW-1:0] rp_t;
  typedef logic signed [NW-1:0]  n_t;
  typedef logic        [NW-1:0]  nmag_t;
  typedef logic signed [CLW-1:0] cl_t;
  typedef logic signed [CHW-1:0] ch_t;
  typedef logic        [RLW-1:0] rl_t;
  typedef logic        [RHW-1:0] rh_t;
  typedef logic signed [DW-1:0]  d_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_e;

  // Classified triangle handed from the front to the back.
  typedef struct packed {
    p_t [2:0][2:0] p;   // [vertex][axis]
    e_t [2:0][2:0] e;   // [edge][axis]
    h_t [2:0]      h;   // doubled box half size per axis
    logic          bb_ok;
  } front_item_t;

endpackage

// ===== design/tbo_if.sv =====
// Channel interfaces: triangle in, result out, configuration write.
`timescale 1ns / 1ps
interface tbo_tri_if;
  logic valid;
  logic ready;
  tbo_pkg::coord_t vert0_x, vert0_y, vert0_z;
  tbo_pkg::coord_t vert1_x, vert1_y, vert1_z;
  tbo_pkg::coord_t vert2_x, vert2_y, vert2_z;
  modport source(output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                 vert2_x, vert2_y, vert2_z, input ready);
  modport sink(input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
               vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface tbo_res_if;
  logic valid;
  logic ready;
  logic overlap;
  modport source(output valid, overlap, input ready);
  modport sink(input valid, overlap, output ready);
endinterface

interface tbo_cfg_if;
  logic valid;
  logic ready;
  logic [tbo_pkg::CFG_IW-1:0] index;
  tbo_pkg::coord_t data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/tbo_front.sv =====
// Front part: box registers, bounding-box test and center-relative triangle setup.
`timescale 1ns / 1ps
module tbo_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tbo_tri_if.sink              tri_i,
  tbo_cfg_if.sink              cfg_i,
  output logic                 push_o,
  output tbo_pkg::front_item_t item_o,
  input  logic                 q_ready_i
);

  tbo_pkg::coord_t      bmin_q [3];
  tbo_pkg::coord_t      bmax_q [3];
  logic                 fv_q;
  tbo_pkg::front_item_t item_q, item_d;
  tbo_pkg::coord_t      v [3][3];
  tbo_pkg::coord_t      lo, hi;
  logic                 accept;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= '0;
        bmax_q[a] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tbo_pkg::REG_BOX_MIN_X: bmin_q[0] <= cfg_i.data;
        tbo_pkg::REG_BOX_MIN_Y: bmin_q[1] <= cfg_i.data;
        tbo_pkg::REG_BOX_MIN_Z: bmin_q[2] <= cfg_i.data;
        tbo_pkg::REG_BOX_MAX_X: bmax_q[0] <= cfg_i.data;
        tbo_pkg::REG_BOX_MAX_Y: bmax_q[1] <= cfg_i.data;
        tbo_pkg::REG_BOX_MAX_Z: bmax_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    v[0][0] = tri_i.vert0_x; v[0][1] = tri_i.vert0_y; v[0][2] = tri_i.vert0_z;
    v[1][0] = tri_i.vert1_x; v[1][1] = tri_i.vert1_y; v[1][2] = tri_i.vert1_z;
    v[2][0] = tri_i.vert2_x; v[2][1] = tri_i.vert2_y; v[2][2] = tri_i.vert2_z;
    item_d.bb_ok = 1'b1;
    lo = '0;
    hi = '0;
    for (int a = 0; a < 3; a++) begin
      lo = v[0][a];
      hi = v[0][a];
      for (int k = 1; k < 3; k++) begin
        if (v[k][a] < lo) lo = v[k][a];
        if (v[k][a] > hi) hi = v[k][a];
      end
      // An inverted box is empty; touching still counts as overlap.
      if (bmin_q[a] > bmax_q[a] || lo > bmax_q[a] || hi < bmin_q[a]) item_d.bb_ok = 1'b0;
      item_d.h[a] = tbo_pkg::h_t'(bmax_q[a] - bmin_q[a]);
      for (int k = 0; k < 3; k++) begin
        item_d.p[k][a] = tbo_pkg::p_t'(v[k][a]) + tbo_pkg::p_t'(v[k][a])
                       - tbo_pkg::p_t'(bmin_q[a]) - tbo_pkg::p_t'(bmax_q[a]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      item_d.e[0][a] = tbo_pkg::e_t'($signed(item_d.p[1][a]))
                     - tbo_pkg::e_t'($signed(item_d.p[0][a]));
      item_d.e[1][a] = tbo_pkg::e_t'($signed(item_d.p[2][a]))
                     - tbo_pkg::e_t'($signed(item_d.p[1][a]));
      item_d.e[2][a] = tbo_pkg::e_t'($signed(item_d.p[0][a]))
                     - tbo_pkg::e_t'($signed(item_d.p[2][a]));
    end
  end

  assign tri_i.ready = !fv_q || q_ready_i;
  assign accept      = tri_i.valid && tri_i.ready;
  assign push_o      = fv_q && q_ready_i;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (push_o) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== design/tbo_queue.sv =====
// Two-entry queue between the front and the back.
`timescale 1ns / 1ps
module tbo_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tbo_pkg::front_item_t item_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output tbo_pkg::front_item_t item_o,
  input  logic                 pop_i
);

  tbo_pkg::front_item_t mem_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== design/tbo_back.sv =====
// Back part: exact plane and edge-axis tests in a five-stage pipeline.
`timescale 1ns / 1ps
module tbo_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tbo_pkg::front_item_t item_i,
  output logic                 pop_o,
  tbo_res_if.source            res_o
);

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage 1: raw products.
  tbo_pkg::pp_t np0_q [3], np1_q [3];
  tbo_pkg::pp_t epa_q [3][3][3], epb_q [3][3][3];
  tbo_pkg::rp_t rpa_q [3][3], rpb_q [3][3];
  tbo_pkg::p_t  p0_1q [3];
  tbo_pkg::h_t  h_1q [3];
  logic         bb_1q;

  // Stage 2: normal, projections, radii.
  tbo_pkg::n_t    n_q [3];
  tbo_pkg::nmag_t nm_q [3];
  tbo_pkg::n_t    pr_q [3][3][3];
  tbo_pkg::n_t    rad_q [3][3];
  tbo_pkg::p_t    p0_2q [3];
  tbo_pkg::h_t    h_2q [3];
  logic           bb_2q;

  // Stage 3: split plane products and edge verdict.
  tbo_pkg::cl_t cl_q [3];
  tbo_pkg::ch_t ch_q [3];
  tbo_pkg::rl_t rl_q [3];
  tbo_pkg::rh_t rh_q [3];
  logic         edge_3q, bb_3q;

  // Stage 4: plane center distance and radius.
  tbo_pkg::d_t c_q, r_q;
  logic        edge_4q, bb_4q;

  // Stage 5: result register.
  logic ok_q;

  tbo_pkg::emag_t em [3][3];
  tbo_pkg::n_t    n_d [3];
  tbo_pkg::n_t    negrad;
  tbo_pkg::d_t    c_d, r_d, cr_sum;
  logic           edge_d, all_hi, all_lo;

  assign adv   = !v5_q || res_o.ready;
  assign pop_o = adv && valid_i;
  assign res_o.valid   = v5_q;
  assign res_o.overlap = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        em[k][a] = item_i.e[k][a][tbo_pkg::EW-1]
                 ? tbo_pkg::emag_t'(-$signed(item_i.e[k][a]))
                 : tbo_pkg::emag_t'(item_i.e[k][a]);
      end
    end
  end

  // Stage 1
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        np0_q[a] <= $signed(item_i.e[0][(a+1)%3]) * $signed(item_i.e[1][(a+2)%3]);
        np1_q[a] <= $signed(item_i.e[0][(a+2)%3]) * $signed(item_i.e[1][(a+1)%3]);
        p0_1q[a] <= item_i.p[0][a];
        h_1q[a]  <= item_i.h[a];
      end
      for (int k = 0; k < 3; k++) begin
        for (int a = 0; a < 3; a++) begin
          rpa_q[k][a] <= em[k][(a+2)%3] * item_i.h[(a+1)%3];
          rpb_q[k][a] <= em[k][(a+1)%3] * item_i.h[(a+2)%3];
          for (int q = 0; q < 3; q++) begin
            epa_q[k][a][q] <= $signed(item_i.e[k][(a+1)%3]) * $signed(item_i.p[q][(a+2)%3]);
            epb_q[k][a][q] <= $signed(item_i.e[k][(a+2)%3]) * $signed(item_i.p[q][(a+1)%3]);
          end
        end
      end
      bb_1q <= item_i.bb_ok;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      n_d[a] = tbo_pkg::n_t'(np0_q[a]) - tbo_pkg::n_t'(np1_q[a]);
    end
  end

  // Stage 2
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        n_q[a]   <= n_d[a];
        nm_q[a]  <= n_d[a][tbo_pkg::NW-1] ? tbo_pkg::nmag_t'(-n_d[a])
                                          : tbo_pkg::nmag_t'(n_d[a]);
        p0_2q[a] <= p0_1q[a];
        h_2q[a]  <= h_1q[a];
      end
      for (int k = 0; k < 3; k++) begin
        for (int a = 0; a < 3; a++) begin
          rad_q[k][a] <= tbo_pkg::n_t'(rpa_q[k][a]) + tbo_pkg::n_t'(rpb_q[k][a]);
          for (int q = 0; q < 3; q++) begin
            pr_q[k][a][q] <= tbo_pkg::n_t'(epa_q[k][a][q]) - tbo_pkg::n_t'(epb_q[k][a][q]);
          end
        end
      end
      bb_2q <= bb_1q;
    end
  end

  // An edge axis separates when all three projections lie beyond the radius on one side.
  always_comb begin
    edge_d = 1'b1;
    negrad = '0;
    all_hi = 1'b0;
    all_lo = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        negrad = -rad_q[k][a];
        all_hi = 1'b1;
        all_lo = 1'b1;
        for (int q = 0; q < 3; q++) begin
          if (!(pr_q[k][a][q] > rad_q[k][a])) all_hi = 1'b0;
          if (!(pr_q[k][a][q] < negrad))      all_lo = 1'b0;
        end
        if (all_hi || all_lo) edge_d = 1'b0;
      end
    end
  end

  // Stage 3
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        cl_q[a] <= $signed({1'b0, n_q[a][tbo_pkg::SPL-1:0]}) * p0_2q[a];
        ch_q[a] <= $signed(n_q[a][tbo_pkg::NW-1:tbo_pkg::SPL]) * p0_2q[a];
        rl_q[a] <= nm_q[a][tbo_pkg::SPL-1:0] * h_2q[a];
        rh_q[a] <= nm_q[a][tbo_pkg::NW-1:tbo_pkg::SPL] * h_2q[a];
      end
      edge_3q <= edge_d;
      bb_3q   <= bb_2q;
    end
  end

  always_comb begin
    c_d = '0;
    r_d = '0;
    for (int a = 0; a < 3; a++) begin
      c_d = c_d + (tbo_pkg::d_t'(ch_q[a]) <<< tbo_pkg::SPL) + tbo_pkg::d_t'(cl_q[a]);
      r_d = r_d + (tbo_pkg::d_t'(rh_q[a]) << tbo_pkg::SPL) + tbo_pkg::d_t'(rl_q[a]);
    end
  end

  // Stage 4
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q     <= c_d;
      r_q     <= r_d;
      edge_4q <= edge_3q;
      bb_4q   <= bb_3q;
    end
  end

  // The plane passes when the center distance lies within the projected radius.
  assign cr_sum = c_q + r_q;

  // Stage 5
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q <= bb_4q && edge_4q && !(c_q > r_q) && !cr_sum[tbo_pkg::DW-1];
    end
  end

endmodule

// ===== design/triangle_box_overlap_test_top.sv =====
// Top level of the triangle versus axis-aligned box overlap test.
`timescale 1ns / 1ps
// Tests each triangle item against the box held in six configuration registers
// (min x, y, z, then max x, y, z; signed Q16.16) and returns one item with overlap
// set when the closed triangle and the closed box touch or intersect. All
// arithmetic is exact. One triangle is accepted every cycle while the output is
// not stalled; a result passes through one front register, one slot of the
// two-entry queue and five back stages (products, normal and edge projections,
// plane products, plane sums, result). Configuration must be written only while
// no triangle is in flight; the block itself does not enforce this.
module triangle_box_overlap_test_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  tbo_tri_if.sink  tri_i,
  tbo_cfg_if.sink  cfg_i,
  tbo_res_if.source res_o
);

  logic                 push, q_ready, q_valid, pop;
  tbo_pkg::front_item_t f_item, q_item;

  tbo_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tri_i     (tri_i),
    .cfg_i     (cfg_i),
    .push_o    (push),
    .item_o    (f_item),
    .q_ready_i (q_ready)
  );

  tbo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (pop)
  );

  tbo_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (q_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
